@@ hw/rtl/apsc_pkg.sv @@
package apsc_pkg;

  localparam int AXIS_W     = 16;
  localparam int SUM_W      = 32;
  localparam int MAG_W      = 16;
  localparam int GAP_W      = 8;
  localparam int SHIFT_W    = 4;
  localparam int THR_W      = 16;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Operation codes of an input beat.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REARM_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMA_SHIFT = 2'd3;

  localparam logic [THR_W-1:0]   STEP_THR_RST  = 16'd614;
  localparam logic [THR_W-1:0]   REARM_THR_RST = 16'd246;
  localparam logic [GAP_W-1:0]   MIN_GAP_RST   = 8'd8;
  localparam logic [SHIFT_W-1:0] EMA_SHIFT_RST = 4'd5;

  typedef struct packed {
    logic [THR_W-1:0]   step_thr;
    logic [THR_W-1:0]   rearm_thr;
    logic [GAP_W-1:0]   min_gap;
    logic [SHIFT_W-1:0] ema_shift;
  } det_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUMSQ,
    ST_SQRT,
    ST_LOAD,
    ST_STEP,
    ST_DECIDE,
    ST_CLEAR
  } state_t;

  typedef enum logic [2:0] {
    DOP_NONE,
    DOP_LOAD,
    DOP_STEP,
    DOP_DECIDE,
    DOP_CLEAR
  } det_op_t;

endpackage

@@ hw/rtl/apsc_sumsq.sv @@
module apsc_sumsq (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [apsc_pkg::AXIS_W-1:0]   ax,
  input  logic signed [apsc_pkg::AXIS_W-1:0]   ay,
  input  logic signed [apsc_pkg::AXIS_W-1:0]   az,
  output logic                                 done,
  output logic        [apsc_pkg::SUM_W-1:0]    sum
);

  logic [apsc_pkg::AXIS_W-1:0] axis_r [3];
  logic [apsc_pkg::SUM_W-1:0]  prod_r;
  logic [apsc_pkg::SUM_W-1:0]  acc_r;
  logic [apsc_pkg::SUM_W-1:0]  sq;
  logic [1:0]                  phase_r;
  logic                        busy_r;
  logic                        done_r;

  function automatic logic [apsc_pkg::AXIS_W-1:0] abs16(
    input logic signed [apsc_pkg::AXIS_W-1:0] v
  );
    abs16 = v[apsc_pkg::AXIS_W-1] ? apsc_pkg::AXIS_W'(-v) : apsc_pkg::AXIS_W'(v);
  endfunction

  assign sq   = axis_r[0] * axis_r[0];
  assign done = done_r;
  assign sum  = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= '0;
      end else if (busy_r) begin
        phase_r <= phase_r + 2'd1;
        if (phase_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // One axis enters the squarer per cycle; the accumulator follows prod_r.
  always_ff @(posedge clk) begin
    if (start) begin
      axis_r[0] <= abs16(ax);
      axis_r[1] <= abs16(ay);
      axis_r[2] <= abs16(az);
      acc_r     <= '0;
    end else if (busy_r) begin
      prod_r    <= sq;
      axis_r[0] <= axis_r[1];
      axis_r[1] <= axis_r[2];
      if (phase_r != 2'd0) begin
        acc_r <= acc_r + prod_r;
      end
    end
  end

endmodule

@@ hw/rtl/apsc_isqrt.sv @@
module apsc_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [apsc_pkg::SUM_W-1:0]    radicand,
  output logic                          done,
  output logic [apsc_pkg::MAG_W-1:0]    root
);

  localparam int REM_W = apsc_pkg::MAG_W + 2;
  localparam int CNT_W = $clog2(apsc_pkg::MAG_W);

  logic [apsc_pkg::SUM_W-1:0] rad_r;
  logic [REM_W-1:0]           rem_r;
  logic [apsc_pkg::MAG_W-1:0] root_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [REM_W+1:0]           rem_sh;
  logic [REM_W+1:0]           trial;
  logic                       ge;
  logic [REM_W+1:0]           rem_diff;

  // Restoring square root, one result bit (two radicand bits) per cycle.
  assign rem_sh   = {rem_r, rad_r[apsc_pkg::SUM_W-1 -: 2]};
  assign trial    = (REM_W+2)'({root_r, 2'b01});
  assign ge       = (rem_sh >= trial);
  assign rem_diff = rem_sh - trial;

  assign done = done_r;
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(apsc_pkg::MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[apsc_pkg::SUM_W-3:0], 2'b00};
      rem_r  <= ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_r <= {root_r[apsc_pkg::MAG_W-2:0], ge};
    end
  end

endmodule

@@ hw/rtl/apsc_detect.sv @@
module apsc_detect #(
  parameter int COUNT_WIDTH        = 32,
  parameter int BASELINE_FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  apsc_pkg::det_op_t               op,
  input  apsc_pkg::det_cfg_t              cfg,
  input  logic [apsc_pkg::MAG_W-1:0]      mag,
  output logic                            detected_nxt,
  output logic [apsc_pkg::TOTAL_W-1:0]    total_nxt,
  output logic                            armed_nxt
);

  localparam int BW = apsc_pkg::MAG_W + BASELINE_FRAC_BITS;

  logic [BW-1:0]                base_r;
  logic                         base_valid_r;
  logic [BW-1:0]                absd_r;
  logic                         up_r;
  logic [BW-1:0]                resid_r;
  logic                         armed_r;
  logic [apsc_pkg::GAP_W-1:0]   gap_r;
  logic [COUNT_WIDTH-1:0]       count_r;

  logic [BW-1:0]                m_val;
  logic [BW-1:0]                b_cur;
  logic [BW:0]                  d_up;
  logic [BW-1:0]                d_dn;
  logic [BW-1:0]                step;
  logic [BW-1:0]                thr_step;
  logic [BW-1:0]                thr_rearm;
  logic                         exceed;
  logic                         rearm;
  logic [apsc_pkg::GAP_W-1:0]   gap_inc;
  logic [apsc_pkg::GAP_W-1:0]   gap_nxt;
  logic [COUNT_WIDTH-1:0]       count_nxt;

  assign m_val     = {mag, {BASELINE_FRAC_BITS{1'b0}}};
  assign b_cur     = base_valid_r ? base_r : m_val;
  assign d_up      = {1'b0, m_val} - {1'b0, b_cur};
  assign d_dn      = b_cur - m_val;
  assign step      = absd_r >> cfg.ema_shift;
  assign thr_step  = {cfg.step_thr, {BASELINE_FRAC_BITS{1'b0}}};
  assign thr_rearm = {cfg.rearm_thr, {BASELINE_FRAC_BITS{1'b0}}};

  // resid_r holds |sample - baseline| after the update; up_r gives its sign.
  assign exceed = up_r && (resid_r > thr_step);
  assign rearm  = up_r ? (resid_r < thr_rearm) :
                  ((resid_r != '0) || (cfg.rearm_thr != '0));

  assign gap_inc = (gap_r == '1) ? gap_r : gap_r + 1'b1;

  always_comb begin
    armed_nxt    = armed_r;
    gap_nxt      = gap_inc;
    count_nxt    = count_r;
    detected_nxt = 1'b0;
    if (armed_r && exceed) begin
      armed_nxt = 1'b0;
      if (gap_inc >= cfg.min_gap) begin
        detected_nxt = 1'b1;
        gap_nxt      = '0;
        if (count_r != '1) begin
          count_nxt = count_r + 1'b1;
        end
      end
    end else if (!armed_r && rearm) begin
      armed_nxt = 1'b1;
    end
  end

  assign total_nxt = apsc_pkg::TOTAL_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      base_valid_r <= 1'b0;
      armed_r      <= 1'b1;
      gap_r        <= '0;
      count_r      <= '0;
    end else begin
      case (op)
        apsc_pkg::DOP_LOAD: begin
          base_r       <= b_cur;
          base_valid_r <= 1'b1;
          up_r         <= ~d_up[BW];
          absd_r       <= d_up[BW] ? d_dn : d_up[BW-1:0];
        end
        apsc_pkg::DOP_STEP: begin
          base_r  <= up_r ? base_r + step : base_r - step;
          resid_r <= absd_r - step;
        end
        apsc_pkg::DOP_DECIDE: begin
          armed_r <= armed_nxt;
          gap_r   <= gap_nxt;
          count_r <= count_nxt;
        end
        apsc_pkg::DOP_CLEAR: begin
          base_r       <= '0;
          base_valid_r <= 1'b0;
          armed_r      <= 1'b1;
          gap_r        <= '0;
          count_r      <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/accel_peak_step_counter.sv @@
// A sample beat passes the shared squarer, the bit-serial square root and the baseline
// and peak logic in turn; a clear beat goes straight to the clear state. One beat is
// in progress at a time, and a new beat is taken only in idle. The next beat is taken
// while a result waits; a new result then waits for the register.
// Reset (synchronous, active low) restores the default thresholds, clears the count,
// the baseline and the gap counter, and arms the detector.
module accel_peak_step_counter #(
  parameter int COUNT_WIDTH        = 32,
  parameter int BASELINE_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_operation,
  input  logic signed [apsc_pkg::AXIS_W-1:0]    in_accel_x,
  input  logic signed [apsc_pkg::AXIS_W-1:0]    in_accel_y,
  input  logic signed [apsc_pkg::AXIS_W-1:0]    in_accel_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_step_detected,
  output logic        [apsc_pkg::TOTAL_W-1:0]   out_step_total,
  output logic        [apsc_pkg::MAG_W-1:0]     out_magnitude,
  output logic                                  out_arm_status,
  input  logic                                  cfg_we,
  input  logic        [apsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [apsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  apsc_pkg::state_t   state_r, state_nxt;
  apsc_pkg::det_op_t  det_op;
  apsc_pkg::det_cfg_t cfg_r;

  logic                          out_valid_r;
  logic                          out_det_r;
  logic [apsc_pkg::TOTAL_W-1:0]  out_total_r;
  logic [apsc_pkg::MAG_W-1:0]    out_mag_r;
  logic                          out_arm_r;

  logic                          out_free;
  logic                          sumsq_start;
  logic                          sum_done;
  logic [apsc_pkg::SUM_W-1:0]    sum;
  logic                          sqrt_done;
  logic [apsc_pkg::MAG_W-1:0]    mag;
  logic                          det_detected;
  logic [apsc_pkg::TOTAL_W-1:0]  det_total;
  logic                          det_armed;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_thr  <= apsc_pkg::STEP_THR_RST;
      cfg_r.rearm_thr <= apsc_pkg::REARM_THR_RST;
      cfg_r.min_gap   <= apsc_pkg::MIN_GAP_RST;
      cfg_r.ema_shift <= apsc_pkg::EMA_SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        apsc_pkg::CFG_STEP_THR:  cfg_r.step_thr  <= cfg_wdata;
        apsc_pkg::CFG_REARM_THR: cfg_r.rearm_thr <= cfg_wdata;
        apsc_pkg::CFG_MIN_GAP:   cfg_r.min_gap   <= cfg_wdata[apsc_pkg::GAP_W-1:0];
        apsc_pkg::CFG_EMA_SHIFT: cfg_r.ema_shift <= cfg_wdata[apsc_pkg::SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      apsc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_operation == apsc_pkg::OP_CLEAR) ? apsc_pkg::ST_CLEAR
                                                           : apsc_pkg::ST_SUMSQ;
        end
      end
      apsc_pkg::ST_SUMSQ:  if (sum_done) state_nxt = apsc_pkg::ST_SQRT;
      apsc_pkg::ST_SQRT:   if (sqrt_done) state_nxt = apsc_pkg::ST_LOAD;
      apsc_pkg::ST_LOAD:   state_nxt = apsc_pkg::ST_STEP;
      apsc_pkg::ST_STEP:   state_nxt = apsc_pkg::ST_DECIDE;
      apsc_pkg::ST_DECIDE: if (out_free) state_nxt = apsc_pkg::ST_IDLE;
      apsc_pkg::ST_CLEAR:  if (out_free) state_nxt = apsc_pkg::ST_IDLE;
      default:             state_nxt = apsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    sumsq_start = 1'b0;
    det_op      = apsc_pkg::DOP_NONE;
    case (state_r)
      apsc_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        sumsq_start = in_valid && (in_operation == apsc_pkg::OP_SAMPLE);
      end
      apsc_pkg::ST_LOAD:   det_op = apsc_pkg::DOP_LOAD;
      apsc_pkg::ST_STEP:   det_op = apsc_pkg::DOP_STEP;
      apsc_pkg::ST_DECIDE: if (out_free) det_op = apsc_pkg::DOP_DECIDE;
      apsc_pkg::ST_CLEAR:  if (out_free) det_op = apsc_pkg::DOP_CLEAR;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apsc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((det_op == apsc_pkg::DOP_DECIDE) || (det_op == apsc_pkg::DOP_CLEAR)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (det_op == apsc_pkg::DOP_DECIDE) begin
      out_det_r   <= det_detected;
      out_total_r <= det_total;
      out_mag_r   <= mag;
      out_arm_r   <= det_armed;
    end else if (det_op == apsc_pkg::DOP_CLEAR) begin
      out_det_r   <= 1'b0;
      out_total_r <= '0;
      out_mag_r   <= '0;
      out_arm_r   <= 1'b1;
    end
  end

  apsc_sumsq u_sumsq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sumsq_start),
    .ax    (in_accel_x),
    .ay    (in_accel_y),
    .az    (in_accel_z),
    .done  (sum_done),
    .sum   (sum)
  );

  apsc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sum_done),
    .radicand (sum),
    .done     (sqrt_done),
    .root     (mag)
  );

  apsc_detect #(
    .COUNT_WIDTH        (COUNT_WIDTH),
    .BASELINE_FRAC_BITS (BASELINE_FRAC_BITS)
  ) u_detect (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (det_op),
    .cfg          (cfg_r),
    .mag          (mag),
    .detected_nxt (det_detected),
    .total_nxt    (det_total),
    .armed_nxt    (det_armed)
  );

  assign out_valid         = out_valid_r;
  assign out_step_detected = out_det_r;
  assign out_step_total    = out_total_r;
  assign out_magnitude     = out_mag_r;
  assign out_arm_status    = out_arm_r;

endmodule

@@ hw/rtl/apsc_checker.sv @@
module apsc_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  out_step_detected,
  input logic        [apsc_pkg::TOTAL_W-1:0]   out_step_total,
  input logic        [apsc_pkg::MAG_W-1:0]     out_magnitude,
  input logic                                  out_arm_status
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_step_total) &&
      $stable(out_magnitude) && $stable(out_step_detected) && $stable(out_arm_status))
    else $error("result beat changed while stalled");

  // One beat at a time: the input side closes right after a beat is taken.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a beat is in progress");

  // A counted step always leaves the detector disarmed.
  a_step_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_detected |-> !out_arm_status)
    else $error("step reported with detector still armed");

  a_step_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_detected |-> out_step_total != '0)
    else $error("step reported with zero total");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind accel_peak_step_counter apsc_checker u_apsc_checker (.*);

@@ test/accel_peak_step_counter_test.sv @@
module accel_peak_step_counter_test;

  typedef struct packed {
    logic                           detected;
    logic [apsc_pkg::TOTAL_W-1:0]   total;
    logic [apsc_pkg::MAG_W-1:0]     mag;
    logic                           armed;
  } step_result_t;

  // Tracks the detector state, predicts one result per accepted input beat
  // and checks the result beats in order.
  class step_scoreboard;
    bit [apsc_pkg::THR_W-1:0]   step_thr;
    bit [apsc_pkg::THR_W-1:0]   rearm_thr;
    bit [apsc_pkg::GAP_W-1:0]   min_gap;
    bit [apsc_pkg::SHIFT_W-1:0] ema_shift;

    bit [apsc_pkg::TOTAL_W-1:0] step_count;
    bit [23:0]                  baseline;
    bit                         seeded;
    bit                         armed;
    bit [apsc_pkg::GAP_W-1:0]   since_step;

    step_result_t expected_q[$];
    int unsigned  errors;

    function new();
      step_thr  = apsc_pkg::STEP_THR_RST;
      rearm_thr = apsc_pkg::REARM_THR_RST;
      min_gap   = apsc_pkg::MIN_GAP_RST;
      ema_shift = apsc_pkg::EMA_SHIFT_RST;
      clear_state();
      errors = 0;
    endfunction

    function void configure(bit [apsc_pkg::THR_W-1:0] s_thr,
                            bit [apsc_pkg::THR_W-1:0] r_thr,
                            bit [apsc_pkg::GAP_W-1:0] gap,
                            bit [apsc_pkg::SHIFT_W-1:0] shift);
      step_thr  = s_thr;
      rearm_thr = r_thr;
      min_gap   = gap;
      ema_shift = shift;
    endfunction

    function void clear_state();
      step_count = '0;
      baseline   = '0;
      seeded     = 1'b0;
      armed      = 1'b1;
      since_step = '0;
    endfunction

    function bit [apsc_pkg::MAG_W-1:0] floor_sqrt(bit [31:0] v);
      bit [apsc_pkg::MAG_W-1:0] root;
      bit [apsc_pkg::MAG_W-1:0] trial;
      bit [63:0]                sq;
      root = '0;
      for (int i = apsc_pkg::MAG_W - 1; i >= 0; i--) begin
        trial = root | (apsc_pkg::MAG_W'(1) << i);
        sq = 64'(trial) * 64'(trial);
        if (sq <= 64'(v)) root = trial;
      end
      return root;
    endfunction

    function void note_input(bit op, bit signed [apsc_pkg::AXIS_W-1:0] x,
                             bit signed [apsc_pkg::AXIS_W-1:0] y,
                             bit signed [apsc_pkg::AXIS_W-1:0] z);
      step_result_t res;
      bit [31:0]    sum;
      bit [23:0]    m;
      int           diff;
      res = '0;
      if (op == apsc_pkg::OP_CLEAR) begin
        clear_state();
      end else begin
        sum = 32'(longint'(x) * x + longint'(y) * y + longint'(z) * z);
        res.mag = floor_sqrt(sum);
        m = {res.mag, 8'b0};
        // The first sample after reset or clear seeds the baseline.
        if (!seeded) begin
          baseline = m;
          seeded = 1'b1;
        end
        if (m >= baseline) baseline = baseline + ((m - baseline) >> ema_shift);
        else baseline = baseline - ((baseline - m) >> ema_shift);
        diff = int'({8'b0, m}) - int'({8'b0, baseline});
        if (since_step != '1) since_step++;
        if (armed && diff > int'({step_thr, 8'b0})) begin
          armed = 1'b0;
          // A peak inside the gap only disarms the detector.
          if (since_step >= min_gap) begin
            if (step_count != '1) step_count++;
            since_step = '0;
            res.detected = 1'b1;
          end
        end else if (!armed && diff < int'({rearm_thr, 8'b0})) begin
          armed = 1'b1;
        end
      end
      res.total = step_count;
      res.armed = armed;
      expected_q.push_back(res);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(step_result_t got);
      step_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.detected !== want.detected) report("step_detected", want.detected, got.detected);
      if (got.total !== want.total) report("step_total", want.total, got.total);
      if (got.mag !== want.mag) report("magnitude", want.mag, got.mag);
      if (got.armed !== want.armed) report("arm_status", want.armed, got.armed);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = apsc_pkg::OP_SAMPLE;
  logic signed [apsc_pkg::AXIS_W-1:0] in_accel_x = '0;
  logic signed [apsc_pkg::AXIS_W-1:0] in_accel_y = '0;
  logic signed [apsc_pkg::AXIS_W-1:0] in_accel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_step_detected;
  logic [apsc_pkg::TOTAL_W-1:0] out_step_total;
  logic [apsc_pkg::MAG_W-1:0] out_magnitude;
  logic out_arm_status;
  logic cfg_we = 1'b0;
  logic [apsc_pkg::CFG_IDX_W-1:0] cfg_index = apsc_pkg::CFG_STEP_THR;
  logic [apsc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  step_scoreboard sb = new();

  accel_peak_step_counter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_accel_x        (in_accel_x),
    .in_accel_y        (in_accel_y),
    .in_accel_z        (in_accel_z),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_step_detected (out_step_detected),
    .out_step_total    (out_step_total),
    .out_magnitude     (out_magnitude),
    .out_arm_status    (out_arm_status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Called right after a rising edge; returns right after the edge that took the beat.
  task automatic send_beat(logic op, logic signed [apsc_pkg::AXIS_W-1:0] x,
                           logic signed [apsc_pkg::AXIS_W-1:0] y,
                           logic signed [apsc_pkg::AXIS_W-1:0] z);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_accel_x   <= x;
    in_accel_y   <= y;
    in_accel_z   <= z;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, x, y, z);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic set_config(bit [apsc_pkg::THR_W-1:0] s_thr,
                            bit [apsc_pkg::THR_W-1:0] r_thr,
                            bit [apsc_pkg::GAP_W-1:0] gap,
                            bit [apsc_pkg::SHIFT_W-1:0] shift);
    cfg_we    <= 1'b1;
    cfg_index <= apsc_pkg::CFG_STEP_THR;
    cfg_wdata <= apsc_pkg::CFG_DATA_W'(s_thr);
    @(posedge clk);
    cfg_index <= apsc_pkg::CFG_REARM_THR;
    cfg_wdata <= apsc_pkg::CFG_DATA_W'(r_thr);
    @(posedge clk);
    cfg_index <= apsc_pkg::CFG_MIN_GAP;
    cfg_wdata <= apsc_pkg::CFG_DATA_W'(gap);
    @(posedge clk);
    cfg_index <= apsc_pkg::CFG_EMA_SHIFT;
    cfg_wdata <= apsc_pkg::CFG_DATA_W'(shift);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.configure(s_thr, r_thr, gap, shift);
  endtask

  // Walking-like motion: about 1 g on a dominant axis with small noise, a peak
  // every few samples followed by a trough, mixed with arbitrary samples and clears.
  task automatic send_walk(int unsigned beats, int unsigned clear_pct);
    int unsigned to_peak;
    int unsigned dom;
    int unsigned pick;
    int          lvl;
    int          ax[3];
    bit          after_peak;
    to_peak = $urandom_range(10, 1);
    dom = $urandom_range(2);
    after_peak = 1'b0;
    repeat (beats) begin
      pick = $urandom_range(99);
      if (pick < clear_pct) begin
        send_beat(apsc_pkg::OP_CLEAR, apsc_pkg::AXIS_W'($urandom),
                  apsc_pkg::AXIS_W'($urandom), apsc_pkg::AXIS_W'($urandom));
      end else if (pick < clear_pct + 10) begin
        send_beat(apsc_pkg::OP_SAMPLE, apsc_pkg::AXIS_W'($urandom),
                  apsc_pkg::AXIS_W'($urandom), apsc_pkg::AXIS_W'($urandom));
      end else begin
        if (to_peak == 0) begin
          lvl = 4096 + int'($urandom_range(3500, 300));
          to_peak = $urandom_range(14, 1);
          after_peak = 1'b1;
        end else if (after_peak) begin
          lvl = 4096 - int'($urandom_range(900));
          after_peak = 1'b0;
          to_peak--;
        end else begin
          lvl = 4046 + int'($urandom_range(100));
          to_peak--;
        end
        if (pick[0]) lvl = -lvl;
        foreach (ax[i]) ax[i] = int'($urandom_range(400)) - 200;
        ax[dom] = lvl;
        send_beat(apsc_pkg::OP_SAMPLE, apsc_pkg::AXIS_W'(ax[0]),
                  apsc_pkg::AXIS_W'(ax[1]), apsc_pkg::AXIS_W'(ax[2]));
        if ($urandom_range(49) == 0) dom = $urandom_range(2);
      end
    end
  endtask

  // Result side: checks every accepted beat and stalls at random or on request.
  initial begin
    step_result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.detected = out_step_detected;
        got.total    = out_step_total;
        got.mag      = out_magnitude;
        got.armed    = out_arm_status;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    send_idle_pct = 37;
    recv_idle_pct = 76;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset thresholds: seed at 1 g, a counted step, a held
    // peak, re-arm, a peak inside the gap, axis extremes and clear with payload.
    repeat (9) send_beat(apsc_pkg::OP_SAMPLE, 16'sd0, 16'sd0, 16'sd4096);
    send_beat(apsc_pkg::OP_SAMPLE, 16'sd0, 16'sd0, 16'sd8000);
    send_beat(apsc_pkg::OP_SAMPLE, 16'sd0, 16'sd0, 16'sd8000);
    send_beat(apsc_pkg::OP_SAMPLE, 16'sd0, 16'sd0, 16'sd4096);
    send_beat(apsc_pkg::OP_SAMPLE, 16'sd0, 16'sd0, 16'sd9000);
    send_beat(apsc_pkg::OP_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
    send_beat(apsc_pkg::OP_SAMPLE, -16'sd32768, -16'sd32768, -16'sd32768);
    send_beat(apsc_pkg::OP_SAMPLE, 16'sd32767, 16'sd32767, 16'sd32767);
    send_beat(apsc_pkg::OP_SAMPLE, 16'sd32767, -16'sd32768, 16'sd1);
    send_beat(apsc_pkg::OP_CLEAR, -16'sd1, -16'sd1, -16'sd1);
    send_beat(apsc_pkg::OP_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
    send_beat(apsc_pkg::OP_SAMPLE, -16'sd1, 16'sd1, -16'sd1);
    send_beat(apsc_pkg::OP_SAMPLE, 16'sh5555, -16'sh2aab, 16'sh0f0f);
    send_beat(apsc_pkg::OP_CLEAR, 16'sd0, 16'sd0, 16'sd0);

    // Lowest step threshold, highest re-arm threshold, no gap and a shift of 1.
    wait_drained();
    set_config(16'd0, 16'hffff, 8'd0, 4'd1);
    send_walk(130, 2);

    // Highest step threshold, lowest re-arm threshold, longest gap, slowest baseline.
    wait_drained();
    set_config(16'hffff, 16'd0, 8'hff, 4'd15);
    send_walk(60, 2);

    // Long gap with no clears, so the gap counter saturates before steps count.
    wait_drained();
    set_config(16'd500, 16'd200, 8'hff, 4'd15);
    send_walk(280, 0);

    send_idle_pct = 76;
    recv_idle_pct = 37;
    // A zero shift makes the baseline track each sample exactly.
    wait_drained();
    set_config(16'd400, 16'd150, 8'd3, 4'd0);
    send_walk(60, 2);

    wait_drained();
    set_config(16'd600, 16'd250, 8'd6, 4'd4);
    send_walk(70, 2);
    wait_drained();
    send_walk(80, 2);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_drained();
    set_config(16'($urandom_range(1500)), 16'($urandom_range(800)),
               8'($urandom_range(12)), 4'($urandom_range(15, 1)));
    send_walk(40, 2);
    // The result side holds off while beats keep coming, so the block backs up.
    hold_left = 400;
    send_walk(110, 2);

    wait_drained();
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
